### rtl/core/mmm_pkg.sv
// shared types and constants for the matrix multiply block
package mmm_pkg;

    localparam int MAX_DIM_DEF     = 8;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int DIM_REG_W       = 4;
    localparam int RESULT_W        = 35;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_B    = 2'd2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // control that travels along the cell chain with each operand
    typedef struct packed {
        logic valid;
        logic first;
    } chain_ctl_t;

endpackage

### rtl/core/matrix_matrix_multiply.sv
// top level of the matrix multiply block: stores, sequencer and cell chain
//
// channel   signals                              handshake
// request   start busy req_type row col value    taken when start and not busy
// config    cfg_valid cfg_ready cfg_index cfg_data  taken when valid and ready
// result    out_valid out_row out_col product_value last  one-cycle strobe
//
// a load request writes its store and leaves the block idle; a compute request
// runs, for each row of a, through feed (one a entry per inner_dim index), drain
// (flushing the cell chain) and emit (one result per column of b)
// the cell chain holds MAX_DIM cells, each adding one register stage
// reset clears control state and sets all three sizes to 8; the stores are
// undefined until written; results cannot be stalled
module matrix_matrix_multiply #(
    parameter int MAX_DIM     = mmm_pkg::MAX_DIM_DEF,
    parameter int VALUE_WIDTH = mmm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           req_type,
    input  logic [2:0]                           row,
    input  logic [2:0]                           col,
    input  logic signed [15:0]                   value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mmm_pkg::DIM_REG_W-1:0]        cfg_data,
    output logic                                 out_valid,
    output logic [2:0]                           out_row,
    output logic [2:0]                           out_col,
    output logic signed [mmm_pkg::RESULT_W-1:0]  product_value,
    output logic                                 last
);

    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int ACC_W     = 2 * VALUE_WIDTH + $clog2(MAX_DIM);
    localparam int EXT_W     = (ACC_W > mmm_pkg::RESULT_W) ? ACC_W : mmm_pkg::RESULT_W;
    localparam int DRAIN_CYC = MAX_DIM + 3;
    localparam int DRAIN_W   = $clog2(DRAIN_CYC + 1);

    mmm_pkg::state_t state_reg;
    mmm_pkg::state_t state_next;

    logic [mmm_pkg::DIM_REG_W-1:0] rows_a_reg;
    logic [mmm_pkg::DIM_REG_W-1:0] inner_dim_reg;
    logic [mmm_pkg::DIM_REG_W-1:0] cols_b_reg;

    logic [DIM_W-1:0] m_eff;
    logic [DIM_W-1:0] n_eff;
    logic [DIM_W-1:0] q_eff;
    logic [IDX_W-1:0] m_last;
    logic [IDX_W-1:0] n_last;
    logic [IDX_W-1:0] q_last;

    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   i_next;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   j_next;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   k_next;
    logic [DRAIN_W-1:0] drain_reg;
    logic [DRAIN_W-1:0] drain_next;

    logic                   accept;
    logic                   idx_ok;
    logic [VALUE_WIDTH-1:0] load_val;
    logic                   a_we;
    logic [2*IDX_W-1:0]     a_addr;
    logic [VALUE_WIDTH-1:0] a_rdata;

    mmm_pkg::chain_ctl_t feed_ctl_next;
    mmm_pkg::chain_ctl_t feed_ctl_reg;
    logic [IDX_W-1:0]    feed_k_reg;

    mmm_pkg::chain_ctl_t    link_ctl [MAX_DIM+1];
    logic [IDX_W-1:0]       link_k   [MAX_DIM+1];
    logic [VALUE_WIDTH-1:0] link_a   [MAX_DIM+1];
    logic signed [ACC_W-1:0] cell_acc [MAX_DIM];

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [2:0]                    out_row_reg;
    logic [2:0]                    out_col_reg;
    logic                          last_reg;
    logic                          last_next;
    logic signed [EXT_W-1:0]       result_ext;
    logic signed [mmm_pkg::RESULT_W-1:0] result_reg;

    assign busy      = (state_reg != mmm_pkg::ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign idx_ok    = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
    assign load_val  = VALUE_WIDTH'($unsigned(value));

    // out-of-range sizes clamp into 1..MAX_DIM
    always_comb
    begin
        if (rows_a_reg == '0)
            m_eff = DIM_W'(1);
        else if (32'(rows_a_reg) > MAX_DIM)
            m_eff = DIM_W'(MAX_DIM);
        else
            m_eff = DIM_W'(rows_a_reg);
        if (inner_dim_reg == '0)
            n_eff = DIM_W'(1);
        else if (32'(inner_dim_reg) > MAX_DIM)
            n_eff = DIM_W'(MAX_DIM);
        else
            n_eff = DIM_W'(inner_dim_reg);
        if (cols_b_reg == '0)
            q_eff = DIM_W'(1);
        else if (32'(cols_b_reg) > MAX_DIM)
            q_eff = DIM_W'(MAX_DIM);
        else
            q_eff = DIM_W'(cols_b_reg);
    end

    assign m_last = IDX_W'(m_eff - DIM_W'(1));
    assign n_last = IDX_W'(n_eff - DIM_W'(1));
    assign q_last = IDX_W'(q_eff - DIM_W'(1));

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mmm_pkg::DIM_RESET;
            inner_dim_reg <= mmm_pkg::DIM_RESET;
            cols_b_reg    <= mmm_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mmm_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_data;
                mmm_pkg::REG_INNER_DIM: inner_dim_reg <= cfg_data;
                mmm_pkg::REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    // a store, row-major
    assign a_we   = accept && (req_type == mmm_pkg::REQ_LOAD_A) && idx_ok;
    assign a_addr = (state_reg == mmm_pkg::ST_FEED) ? {i_reg, k_reg}
                                                    : {row[IDX_W-1:0], col[IDX_W-1:0]};

    mmm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (2 ** (2 * IDX_W))
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .addr  (a_addr),
        .wdata (load_val),
        .rdata (a_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        drain_next     = drain_reg;
        feed_ctl_next  = '0;
        out_valid_next = 1'b0;
        last_next      = 1'b0;
        unique case (state_reg)
            mmm_pkg::ST_IDLE:
            begin
                if (accept && (req_type == mmm_pkg::REQ_COMPUTE))
                begin
                    state_next = mmm_pkg::ST_FEED;
                    i_next     = '0;
                    k_next     = '0;
                end
            end
            mmm_pkg::ST_FEED:
            begin
                feed_ctl_next.valid = 1'b1;
                feed_ctl_next.first = (k_reg == '0);
                if (k_reg == n_last)
                begin
                    state_next = mmm_pkg::ST_DRAIN;
                    drain_next = '0;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            mmm_pkg::ST_DRAIN:
            begin
                if (drain_reg == DRAIN_W'(DRAIN_CYC - 1))
                begin
                    state_next = mmm_pkg::ST_EMIT;
                    j_next     = '0;
                end
                else
                begin
                    drain_next = drain_reg + DRAIN_W'(1);
                end
            end
            mmm_pkg::ST_EMIT:
            begin
                out_valid_next = 1'b1;
                if (j_reg == q_last)
                begin
                    if (i_reg == m_last)
                    begin
                        last_next  = 1'b1;
                        state_next = mmm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        k_next     = '0;
                        state_next = mmm_pkg::ST_FEED;
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = mmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmm_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            drain_reg     <= '0;
            feed_ctl_reg  <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            drain_reg     <= drain_next;
            feed_ctl_reg  <= feed_ctl_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        feed_k_reg <= k_reg;
        if (state_reg == mmm_pkg::ST_EMIT)
        begin
            out_row_reg <= 3'(i_reg);
            out_col_reg <= 3'(j_reg);
            result_reg  <= result_ext[mmm_pkg::RESULT_W-1:0];
        end
    end

    assign result_ext = EXT_W'(cell_acc[j_reg]);

    // cell chain
    assign link_ctl[0] = feed_ctl_reg;
    assign link_k[0]   = feed_k_reg;
    assign link_a[0]   = a_rdata;

    for (genvar c = 0; c < MAX_DIM; c++)
    begin : g_cell
        logic b_we_c;

        assign b_we_c = accept && (req_type == mmm_pkg::REQ_LOAD_B) && idx_ok
                        && (32'(col) == c);

        mmm_cell #(
            .MAX_DIM     (MAX_DIM),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX_W       (IDX_W),
            .ACC_W       (ACC_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_ctl  (link_ctl[c]),
            .in_k    (link_k[c]),
            .in_a    (link_a[c]),
            .out_ctl (link_ctl[c+1]),
            .out_k   (link_k[c+1]),
            .out_a   (link_a[c+1]),
            .b_we    (b_we_c),
            .b_addr  (row[IDX_W-1:0]),
            .b_data  (load_val),
            .acc     (cell_acc[c])
        );
    end

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = result_reg;
    assign last          = out_valid_reg && last_reg;

    // results only follow an emit cycle
    a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(state_reg == mmm_pkg::ST_EMIT))
        else $error("result strobe without emit cycle");

    // the final result of a run returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (state_reg == mmm_pkg::ST_IDLE))
        else $error("last result while still running");

    // the feed index stays within the inner dimension
    a_feed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmm_pkg::ST_FEED) |-> (k_reg <= n_last))
        else $error("feed index beyond inner dimension");

    // no feed activity reaches the chain outside a feed cycle
    a_feed_src: assert property (@(posedge clk) disable iff (!rst_n)
        feed_ctl_reg.valid |-> $past(state_reg == mmm_pkg::ST_FEED))
        else $error("chain fed outside feed state");

endmodule

### rtl/core/mmm_ram.sv
// generic single-port ram with registered read
module mmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/mmm_cell.sv
// one chain cell: holds a column of b, multiplies and accumulates one result column
module mmm_cell #(
    parameter int MAX_DIM     = mmm_pkg::MAX_DIM_DEF,
    parameter int VALUE_WIDTH = mmm_pkg::VALUE_WIDTH_DEF,
    parameter int IDX_W       = $clog2(MAX_DIM),
    parameter int ACC_W       = 2 * VALUE_WIDTH + $clog2(MAX_DIM)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mmm_pkg::chain_ctl_t     in_ctl,
    input  logic [IDX_W-1:0]        in_k,
    input  logic [VALUE_WIDTH-1:0]  in_a,
    output mmm_pkg::chain_ctl_t     out_ctl,
    output logic [IDX_W-1:0]        out_k,
    output logic [VALUE_WIDTH-1:0]  out_a,
    input  logic                    b_we,
    input  logic [IDX_W-1:0]        b_addr,
    input  logic [VALUE_WIDTH-1:0]  b_data,
    output logic signed [ACC_W-1:0] acc
);

    logic [VALUE_WIDTH-1:0] b_col [MAX_DIM];

    mmm_pkg::chain_ctl_t            pass_ctl_reg;
    logic [IDX_W-1:0]               pass_k_reg;
    logic [VALUE_WIDTH-1:0]         pass_a_reg;
    mmm_pkg::chain_ctl_t            prod_ctl_reg;
    logic signed [2*VALUE_WIDTH-1:0] prod_reg;
    logic signed [2*VALUE_WIDTH-1:0] prod_next;
    logic signed [VALUE_WIDTH-1:0]  a_s;
    logic signed [VALUE_WIDTH-1:0]  b_s;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;

    assign a_s       = signed'(in_a);
    assign b_s       = signed'(b_col[in_k]);
    assign prod_next = a_s * b_s;

    always_comb
    begin
        acc_next = acc_reg;
        if (prod_ctl_reg.valid)
        begin
            if (prod_ctl_reg.first)
            begin
                acc_next = ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_col[b_addr] <= b_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_ctl_reg <= '0;
            prod_ctl_reg <= '0;
        end
        else
        begin
            pass_ctl_reg <= in_ctl;
            prod_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_k_reg <= in_k;
        pass_a_reg <= in_a;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
    end

    assign out_ctl = pass_ctl_reg;
    assign out_k   = pass_k_reg;
    assign out_a   = pass_a_reg;
    assign acc     = acc_reg;

endmodule

### dv/tb_matrix_matrix_multiply.sv
// testbench for the matrix multiply block: random loads and computes checked against a predictor
`timescale 1ns / 100ps

module tb_matrix_matrix_multiply;

    localparam int DIM = 8;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [mmm_pkg::CFG_INDEX_W-1:0] REG_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_GOAL = 360;

    typedef struct {
        logic [2:0]                   r;
        logic [2:0]                   c;
        logic [mmm_pkg::RESULT_W-1:0] prod;
        logic                         lst;
    } elem_t;

    class gemm_scoreboard;
        logic signed [15:0] a_mem [DIM*DIM];
        logic signed [15:0] b_mem [DIM*DIM];
        bit a_wr [DIM*DIM];
        bit b_wr [DIM*DIM];
        logic [mmm_pkg::DIM_REG_W-1:0] dim_reg [3];
        elem_t pending [$];
        int errors;
        int results;
        int computes;

        function new();
            dim_reg[0] = mmm_pkg::DIM_RESET;
            dim_reg[1] = mmm_pkg::DIM_RESET;
            dim_reg[2] = mmm_pkg::DIM_RESET;
            errors = 0;
            results = 0;
            computes = 0;
            foreach (a_wr[i])
            begin
                a_wr[i] = 0;
                b_wr[i] = 0;
            end
        endfunction

        function int eff(int idx);
            if (dim_reg[idx] == 0)
                return 1;
            if (int'(dim_reg[idx]) > DIM)
                return DIM;
            return int'(dim_reg[idx]);
        endfunction

        function void write_reg(logic [mmm_pkg::CFG_INDEX_W-1:0] idx,
                                logic [mmm_pkg::DIM_REG_W-1:0] d);
            if (idx == mmm_pkg::REG_ROWS_A)
                dim_reg[0] = d;
            else if (idx == mmm_pkg::REG_INNER_DIM)
                dim_reg[1] = d;
            else if (idx == mmm_pkg::REG_COLS_B)
                dim_reg[2] = d;
        endfunction

        function void note_request(logic [1:0] rt, logic [2:0] r, logic [2:0] c,
                                   logic signed [15:0] v);
            int m;
            int n;
            int q;
            longint acc;
            elem_t e;
            if (rt == mmm_pkg::REQ_LOAD_A)
            begin
                a_mem[r*DIM+c] = v;
                a_wr[r*DIM+c] = 1;
            end
            else if (rt == mmm_pkg::REQ_LOAD_B)
            begin
                b_mem[r*DIM+c] = v;
                b_wr[r*DIM+c] = 1;
            end
            else if (rt == mmm_pkg::REQ_COMPUTE)
            begin
                computes++;
                m = eff(0);
                n = eff(1);
                q = eff(2);
                for (int i = 0; i < m; i++)
                    for (int j = 0; j < q; j++)
                    begin
                        acc = 0;
                        for (int k = 0; k < n; k++)
                            acc += longint'(a_mem[i*DIM+k]) * longint'(b_mem[k*DIM+j]);
                        e.r = 3'(i);
                        e.c = 3'(j);
                        e.prod = acc[mmm_pkg::RESULT_W-1:0];
                        e.lst = (i == m-1) && (j == q-1);
                        pending.push_back(e);
                    end
            end
        endfunction

        function void check_result(logic [2:0] r, logic [2:0] c,
                                   logic [mmm_pkg::RESULT_W-1:0] p, logic l);
            elem_t e;
            results++;
            if (pending.size() == 0)
            begin
                $error("result with none expected: row %0d col %0d", r, c);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r !== e.r)
            begin
                $error("out_row expected %0d actual %0d", e.r, r);
                errors++;
            end
            if (c !== e.c)
            begin
                $error("out_col expected %0d actual %0d", e.c, c);
                errors++;
            end
            if (p !== e.prod)
            begin
                $error("product_value expected %h actual %h", e.prod, p);
                errors++;
            end
            if (l !== e.lst)
            begin
                $error("last expected %0d actual %0d", e.lst, l);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] req_type;
    logic [2:0] row;
    logic [2:0] col;
    logic signed [15:0] value;
    logic cfg_valid;
    logic cfg_ready;
    logic [mmm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mmm_pkg::DIM_REG_W-1:0] cfg_data;
    logic out_valid;
    logic [2:0] out_row;
    logic [2:0] out_col;
    logic signed [mmm_pkg::RESULT_W-1:0] product_value;
    logic last;

    gemm_scoreboard sb;
    int items;
    int cycles;
    bit calm;

    matrix_matrix_multiply dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .row(row),
        .col(col),
        .value(value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .out_row(out_row),
        .out_col(out_col),
        .product_value(product_value),
        .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid)
            sb.check_result(out_row, out_col, product_value, last);

    // drives one request; start stays high for back-to-back requests
    task automatic send_req(logic [1:0] rt, logic [2:0] r, logic [2:0] c, logic [15:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        start <= 1'b1;
        req_type <= rt;
        row <= r;
        col <= c;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(rt, r, c, v);
        if (rt != REQ_UNUSED)
            items++;
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [mmm_pkg::CFG_INDEX_W-1:0] idx,
                             logic [mmm_pkg::DIM_REG_W-1:0] d);
        start <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // the sender holds off until every expected result is back
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0 || busy)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic set_dims(logic [3:0] m, logic [3:0] n, logic [3:0] q);
        drain();
        write_cfg(mmm_pkg::REG_ROWS_A, m);
        write_cfg(mmm_pkg::REG_INNER_DIM, n);
        write_cfg(mmm_pkg::REG_COLS_B, q);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // load every entry the next compute reads that has never been written
    task automatic fill_needed();
        for (int i = 0; i < sb.eff(0); i++)
            for (int k = 0; k < sb.eff(1); k++)
                if (!sb.a_wr[i*DIM+k])
                    send_req(mmm_pkg::REQ_LOAD_A, 3'(i), 3'(k), rand_value());
        for (int k = 0; k < sb.eff(1); k++)
            for (int j = 0; j < sb.eff(2); j++)
                if (!sb.b_wr[k*DIM+j])
                    send_req(mmm_pkg::REQ_LOAD_B, 3'(k), 3'(j), rand_value());
    endtask

    task automatic compute();
        fill_needed();
        send_req(mmm_pkg::REQ_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    task automatic random_phase(int count);
        int stop;
        int pick;
        stop = items + count;
        while (items < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_req(mmm_pkg::REQ_LOAD_A, 3'($urandom_range(0, sb.eff(0)-1)),
                         3'($urandom_range(0, sb.eff(1)-1)), rand_value());
            else if (pick < 60)
                send_req(mmm_pkg::REQ_LOAD_B, 3'($urandom_range(0, sb.eff(1)-1)),
                         3'($urandom_range(0, sb.eff(2)-1)), rand_value());
            else if (pick < 72)
                send_req(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom), rand_value());
            else if (pick < 78)
                send_req(REQ_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom));
            else
                compute();
        end
        compute();
    endtask

    initial
    begin
        sb = new();
        items = 0;
        cycles = 0;
        calm = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = mmm_pkg::REQ_LOAD_A;
        row = '0;
        col = '0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_index = mmm_pkg::REG_ROWS_A;
        cfg_data = mmm_pkg::DIM_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single-element extremes
        set_dims(4'd1, 4'd1, 4'd1);
        send_req(mmm_pkg::REQ_LOAD_A, 3'd0, 3'd0, 16'h8000);
        send_req(mmm_pkg::REQ_LOAD_B, 3'd0, 3'd0, 16'h8000);
        send_req(mmm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
        send_req(mmm_pkg::REQ_LOAD_A, 3'd0, 3'd0, 16'h7fff);
        send_req(mmm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
        send_req(mmm_pkg::REQ_LOAD_B, 3'd0, 3'd0, 16'h7fff);
        send_req(mmm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
        send_req(REQ_UNUSED, 3'd7, 3'd7, 16'hffff);
        write_cfg(REG_NONE, 4'hf);
        send_req(mmm_pkg::REQ_LOAD_A, 3'd7, 3'd7, 16'h0100);
        send_req(mmm_pkg::REQ_LOAD_B, 3'd7, 3'd7, 16'hff00);
        send_req(mmm_pkg::REQ_COMPUTE, 3'd7, 3'd7, 16'hffff);

        // zero and oversize registers clamp; matrix-vector shape
        set_dims(4'd0, 4'd15, 4'd0);
        compute();
        set_dims(4'd9, 4'd1, 4'd1);
        compute();
        set_dims(4'd8, 4'd8, 4'd8);
        compute();
        random_phase(30);

        set_dims(4'd1, 4'd8, 4'd1);
        random_phase(30);
        while (items < ITEM_GOAL)
        begin
            if (items > ITEM_GOAL - 60)
                calm = 1;
            set_dims(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)));
            random_phase($urandom_range(15, 40));
        end

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        $display("ran %0d requests with %0d computes, %0d result elements checked",
                 items, sb.computes, sb.results);
        $display("sizes covered 0 to 15 per register, values at both extremes");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/core/mmm_pkg.sv
rtl/core/mmm_ram.sv
rtl/core/mmm_cell.sv
rtl/core/matrix_matrix_multiply.sv
dv/tb_matrix_matrix_multiply.sv
